>>> design/button_click_classifier_assert.svh
// Assertion macros for the button click classifier.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BCC_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// implication checked in the cycle after the condition
`define BCC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> design/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies.
package bcc_pkg;

   localparam int TIMER_W = 16;
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = TIMER_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_CLICK = 2'd2;

   // register reset values
   localparam logic [TIMER_W-1:0] DEBOUNCE_RESET     = 16'd50;
   localparam logic [TIMER_W-1:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [TIMER_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

   // event codes
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SINGLE = 2'd1;
   localparam logic [1:0] EV_DOUBLE = 2'd2;
   localparam logic [1:0] EV_LONG   = 2'd3;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_PRESSED = 3'd1,
      MODE_LONG    = 3'd2,
      MODE_WAIT    = 3'd3
   } mode_type;

   // debounced level changes for one tick
   typedef struct packed {
      logic press_edge;
      logic release_edge;
   } level_change_type;

   function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
      sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
   endfunction

endpackage

>>> design/bcc_debounce.sv
// Debouncer: accepts a raw level once it has been stable longer than the limit.
// Depends on bcc_pkg.
module bcc_debounce (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         raw_level,
   input  logic [bcc_pkg::TIMER_W-1:0]  debounce_ticks,
   output bcc_pkg::level_change_type    change,
   output logic                         level_next
);
   import bcc_pkg::*;

   logic               previous_raw_ff, previous_raw_in;
   logic [TIMER_W-1:0] settle_count_ff, settle_count_in;
   logic               level_ff;

   always_comb begin
      if (raw_level != previous_raw_ff) begin
         settle_count_in = '0;
      end else begin
         settle_count_in = sat_inc(settle_count_ff);
      end
      previous_raw_in = raw_level;

      change.press_edge   = 1'b0;
      change.release_edge = 1'b0;
      level_next          = level_ff;
      if ((settle_count_in > debounce_ticks) && (raw_level != level_ff)) begin
         level_next = raw_level;
         if (raw_level == LEVEL_PRESSED) begin
            change.press_edge = 1'b1;
         end else begin
            change.release_edge = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= LEVEL_RELEASED;
         settle_count_ff <= '0;
         level_ff        <= LEVEL_RELEASED;
      end else if (step) begin
         previous_raw_ff <= previous_raw_in;
         settle_count_ff <= settle_count_in;
         level_ff        <= level_next;
      end
   end

endmodule

>>> design/bcc_fsm.sv
// Click classifier state machine: hold and gap timers, click tally, events.
// Depends on bcc_pkg.
module bcc_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  bcc_pkg::level_change_type    change,
   input  logic [bcc_pkg::TIMER_W-1:0]  long_press_ticks,
   input  logic [bcc_pkg::TIMER_W-1:0]  double_click_ticks,
   output logic [1:0]                   event_code
);
   import bcc_pkg::*;

   mode_type           mode_ff, mode_in, mode_edge;
   logic [TIMER_W-1:0] hold_ff, hold_in;
   logic [TIMER_W-1:0] gap_ff, gap_in;
   logic [1:0]         tally_ff, tally_in, tally_edge;
   logic               long_hit, gap_hit;

   // edge handling, then timeout checks on the updated mode
   always_comb begin
      mode_edge  = mode_ff;
      hold_in    = hold_ff;
      gap_in     = gap_ff;
      tally_edge = tally_ff;
      unique case (mode_ff)
         MODE_PRESSED, MODE_LONG, MODE_WAIT: mode_edge = mode_ff;
         default:                            mode_edge = MODE_IDLE;
      endcase
      if (change.press_edge) begin
         mode_edge = MODE_PRESSED;
         hold_in   = '0;
      end else if (change.release_edge) begin
         if (mode_edge == MODE_PRESSED) begin
            if (tally_ff != 2'd3) begin
               tally_edge = tally_ff + 2'd1;
            end
            mode_edge = MODE_WAIT;
            gap_in    = '0;
         end else if (mode_edge == MODE_LONG) begin
            mode_edge = MODE_IDLE;
         end
      end else if (mode_edge == MODE_PRESSED) begin
         hold_in = sat_inc(hold_ff);
      end else if (mode_edge == MODE_WAIT) begin
         gap_in = sat_inc(gap_ff);
      end

      long_hit = (mode_edge == MODE_PRESSED) && (hold_in >= long_press_ticks);
      gap_hit  = (mode_edge == MODE_WAIT) && (gap_in >= double_click_ticks);

      mode_in  = mode_edge;
      tally_in = tally_edge;
      if (long_hit) begin
         mode_in  = MODE_LONG;
         tally_in = 2'd0;
      end else if (gap_hit) begin
         mode_in  = MODE_IDLE;
         tally_in = 2'd0;
      end
   end

   always_comb begin
      event_code = EV_NONE;
      if (long_hit) begin
         event_code = EV_LONG;
      end else if (gap_hit) begin
         case (tally_edge)
            2'd1:    event_code = EV_SINGLE;
            2'd2:    event_code = EV_DOUBLE;
            default: event_code = EV_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         hold_ff  <= '0;
         gap_ff   <= '0;
         tally_ff <= 2'd0;
      end else if (step) begin
         mode_ff  <= mode_in;
         hold_ff  <= hold_in;
         gap_ff   <= gap_in;
         tally_ff <= tally_in;
      end
   end

endmodule

>>> design/button_click_classifier.sv
// Button click classifier. Each request is one time tick carrying the raw
// active-low pin level. The level is debounced (accepted once unchanged for
// more than debounce_ticks ticks) and a state machine turns the debounced
// level into single click, double click and long press events. Every request
// produces exactly one response: the event code for that tick and whether the
// button is held after it. Throughput is one request per clock while rsp_stall
// is low; the response appears in the output register in the cycle after
// acceptance: the debounce and state update is combinational logic feeding it.
// A request is taken while a response is still waiting as long as that
// response is being taken in the same cycle. Registers (csr_index): 0 debounce
// ticks, 1 long press ticks, 2 double click window; other indexes are ignored.
// Depends on bcc_pkg, bcc_debounce, bcc_fsm and the assertion macro header.
`include "button_click_classifier_assert.svh"

module button_click_classifier (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_raw_level,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_code,
   output logic                            rsp_is_held,
   // configuration writes
   input  logic                            csr_write_enable,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bcc_pkg::*;

   logic [TIMER_W-1:0] debounce_ff, long_press_ff, double_click_ff;

   logic               step;
   level_change_type   change;
   logic               level_next;
   logic [1:0]         event_code;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_event_ff;
   logic               rsp_held_ff;

   // output register is free when empty or being drained this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RESET;
         long_press_ff   <= LONG_PRESS_RESET;
         double_click_ff <= DOUBLE_CLICK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_write_data;
            CSR_LONG_PRESS:   long_press_ff   <= csr_write_data;
            CSR_DOUBLE_CLICK: double_click_ff <= csr_write_data;
            default:          ;
         endcase
      end
   end

   bcc_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw_level      (req_raw_level),
      .debounce_ticks (debounce_ff),
      .change         (change),
      .level_next     (level_next)
   );

   bcc_fsm u_fsm (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .change             (change),
      .long_press_ticks   (long_press_ff),
      .double_click_ticks (double_click_ff),
      .event_code         (event_code)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_ff <= event_code;
         rsp_held_ff  <= (level_next == LEVEL_PRESSED);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;
   assign rsp_is_held    = rsp_held_ff;

   // a long press is only reported while the button is down
   `BCC_ASSERT_IMPLY(a_long_held, rsp_valid && (rsp_event_code == EV_LONG), rsp_is_held,
                     "long press reported while released")
   // clicks are only reported once the button is up
   `BCC_ASSERT_IMPLY(a_click_released,
                     rsp_valid && ((rsp_event_code == EV_SINGLE) ||
                                   (rsp_event_code == EV_DOUBLE)),
                     !rsp_is_held, "click reported while held")
   // every accepted request shows up as a response in the next cycle
   `BCC_ASSERT_NEXT(a_req_to_rsp, req_valid && !req_stall, rsp_valid,
                    "accepted request produced no response")

endmodule
